### design/small_register_machine_executor_core_assert.svh
// Assertion macros shared by the design files.
`ifndef SMALL_REGISTER_MACHINE_EXECUTOR_CORE_ASSERT_SVH
`define SMALL_REGISTER_MACHINE_EXECUTOR_CORE_ASSERT_SVH

// Implication checked at every clock edge outside reset.
`define SRM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication whose consequence is checked in the next cycle.
`define SRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### design/srme_pkg.sv
package srme_pkg;
	localparam int WordBits   = 32;
	localparam int MemWords   = 4096;
	localparam int MemAw      = $clog2(MemWords);
	localparam int StackDepth = 64;
	localparam int StackAw    = $clog2(StackDepth);
	localparam int NumRegs    = 9;
	localparam logic [3:0] PcReg = 4'd8;

	typedef logic [WordBits-1:0] word_t;

	localparam logic [3:0] OP_MOV  = 4'd0;
	localparam logic [3:0] OP_PMOV = 4'd1;
	localparam logic [3:0] OP_ADD  = 4'd2;
	localparam logic [3:0] OP_SUB  = 4'd3;
	localparam logic [3:0] OP_MUL  = 4'd4;
	localparam logic [3:0] OP_DIV  = 4'd5;
	localparam logic [3:0] OP_INC  = 4'd6;
	localparam logic [3:0] OP_CMP  = 4'd7;
	localparam logic [3:0] OP_JEQ  = 4'd8;
	localparam logic [3:0] OP_JLT  = 4'd9;
	localparam logic [3:0] OP_JGT  = 4'd10;
	localparam logic [3:0] OP_PUSH = 4'd11;
	localparam logic [3:0] OP_POP  = 4'd12;
	localparam logic [3:0] OP_INT  = 4'd13;

	localparam logic [1:0] MODE_REG = 2'd0;
	localparam logic [1:0] MODE_DIR = 2'd1;
	localparam logic [1:0] MODE_IND = 2'd2;
	localparam logic [1:0] MODE_IMM = 2'd3;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_KIND  = 3'd1;
	localparam logic [2:0] ST_DIV0  = 3'd2;
	localparam logic [2:0] ST_OVER  = 3'd3;
	localparam logic [2:0] ST_UNDER = 3'd4;

	// Operand slot the datapath resolves
	typedef enum logic [1:0] {
		SLOT_A = 2'd0,
		SLOT_B = 2'd1,
		SLOT_D = 2'd2
	} slot_t;

	typedef struct packed {
		logic  latch;      // capture instruction
		logic  mem_rd;     // issue memory read at operand address
		logic  mem_ind;    // address from previous memory data
		slot_t slot;
		logic  op_cap;     // capture read data into slot
		logic  div_start;
		logic  commit;     // perform write back and pc update
		logic  out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic       div_busy;
		logic [3:0] opcode;
		logic [1:0] dest_mode;
		logic [1:0] a_mode;
		logic [1:0] b_mode;
		logic       halted;
	} dp_stat_t;

	typedef struct packed {
		logic [31:0] next_pc;
		logic        print_valid;
		logic        print_is_char;
		logic [31:0] print_value;
		logic        halted;
		logic [2:0]  status;
	} res_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [1:0]  dest_mode;
		logic [11:0] dest_value;
		logic [1:0]  a_mode;
		logic [31:0] a_value;
		logic [1:0]  b_mode;
		logic [31:0] b_value;
	} instr_t;
endpackage

### design/srme_if.sv
interface srme_in_if;
	logic              valid;
	logic              ready;
	srme_pkg::instr_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface srme_out_if;
	logic            valid;
	logic            ready;
	srme_pkg::res_t  payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/srme_div.sv
// Restoring signed divider, one quotient bit per cycle.
module srme_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  srme_pkg::word_t     dividend,
	input  srme_pkg::word_t     divisor,
	output logic                busy,
	output srme_pkg::word_t     quotient
);
	localparam int CntW = $clog2(srme_pkg::WordBits + 1);
	srme_pkg::word_t q_q, d_q;
	logic [srme_pkg::WordBits:0] r_q;
	logic [CntW-1:0] cnt_q;
	logic neg_q;
	logic [srme_pkg::WordBits:0] trial;

	assign trial = {r_q[srme_pkg::WordBits-1:0], q_q[srme_pkg::WordBits-1]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(srme_pkg::WordBits);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend[srme_pkg::WordBits-1] ? -dividend : dividend;
			d_q   <= divisor[srme_pkg::WordBits-1] ? -divisor : divisor;
			r_q   <= '0;
			neg_q <= dividend[srme_pkg::WordBits-1] ^ divisor[srme_pkg::WordBits-1];
		end else if (cnt_q != '0) begin
			if (!trial[srme_pkg::WordBits]) begin
				r_q <= trial;
				q_q <= {q_q[srme_pkg::WordBits-2:0], 1'b1};
			end else begin
				r_q <= {r_q[srme_pkg::WordBits-1:0], q_q[srme_pkg::WordBits-1]};
				q_q <= {q_q[srme_pkg::WordBits-2:0], 1'b0};
			end
		end
	end

	assign busy     = (cnt_q != '0);
	assign quotient = neg_q ? -q_q : q_q;
endmodule

### design/srme_datapath.sv
// Register file, memories, operand slots, ALU and result register.
module srme_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  srme_pkg::instr_t   instr,
	input  srme_pkg::dp_cmd_t  cmd,
	output srme_pkg::dp_stat_t stat,
	output srme_pkg::res_t     res
);
	srme_pkg::instr_t  ins_q;
	srme_pkg::word_t   regs_q [srme_pkg::NumRegs];
	srme_pkg::word_t   cmp_q;
	srme_pkg::word_t   mem [srme_pkg::MemWords];
	srme_pkg::word_t   stk [srme_pkg::StackDepth];
	srme_pkg::word_t   mem_rd_q, stk_rd_q;
	logic [srme_pkg::StackAw:0] sp_q;
	logic              halt_q;
	srme_pkg::word_t   a_q, b_q, d_q;
	srme_pkg::word_t   prod_q;
	logic [srme_pkg::MemAw-1:0] wr_adr_q;
	srme_pkg::word_t   quot;
	logic              div_busy;

	srme_pkg::word_t   slot_val;
	logic [1:0]        slot_mode;
	srme_pkg::word_t   slot_imm;
	logic [srme_pkg::MemAw-1:0] rd_adr;
	srme_pkg::word_t   reg_a, reg_b, reg_d;

	function automatic srme_pkg::word_t reg_rd(input logic [31:0] idx,
			input srme_pkg::word_t r0, input srme_pkg::word_t r1, input srme_pkg::word_t r2,
			input srme_pkg::word_t r3, input srme_pkg::word_t r4, input srme_pkg::word_t r5,
			input srme_pkg::word_t r6, input srme_pkg::word_t r7, input srme_pkg::word_t r8);
		srme_pkg::word_t v;
		case (idx)
			32'd0: v = r0;
			32'd1: v = r1;
			32'd2: v = r2;
			32'd3: v = r3;
			32'd4: v = r4;
			32'd5: v = r5;
			32'd6: v = r6;
			32'd7: v = r7;
			32'd8: v = r8;
			default: v = '0;
		endcase
		return v;
	endfunction

	assign reg_a = reg_rd(ins_q.a_value, regs_q[0], regs_q[1], regs_q[2], regs_q[3],
		regs_q[4], regs_q[5], regs_q[6], regs_q[7], regs_q[8]);
	assign reg_b = reg_rd(ins_q.b_value, regs_q[0], regs_q[1], regs_q[2], regs_q[3],
		regs_q[4], regs_q[5], regs_q[6], regs_q[7], regs_q[8]);
	assign reg_d = reg_rd({20'd0, ins_q.dest_value}, regs_q[0], regs_q[1], regs_q[2],
		regs_q[3], regs_q[4], regs_q[5], regs_q[6], regs_q[7], regs_q[8]);

	always_comb begin
		case (cmd.slot)
			srme_pkg::SLOT_A: begin
				slot_mode = ins_q.a_mode;
				slot_imm  = ins_q.a_value;
				slot_val  = reg_a;
			end
			srme_pkg::SLOT_B: begin
				slot_mode = ins_q.b_mode;
				slot_imm  = ins_q.b_value;
				slot_val  = reg_b;
			end
			default: begin
				slot_mode = ins_q.dest_mode;
				slot_imm  = {20'd0, ins_q.dest_value};
				slot_val  = reg_d;
			end
		endcase
		rd_adr = cmd.mem_ind ? mem_rd_q[srme_pkg::MemAw-1:0] : slot_imm[srme_pkg::MemAw-1:0];
	end

	srme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (reg_a),
		.divisor  (reg_b),
		.busy     (div_busy),
		.quotient (quot)
	);

	// Memory reads; the last address read doubles as the write address
	always_ff @(posedge clk) begin
		if (cmd.mem_rd) begin
			mem_rd_q <= mem[rd_adr];
			wr_adr_q <= rd_adr;
		end
		stk_rd_q <= stk[sp_q[srme_pkg::StackAw-1:0] - 1'b1];
		prod_q   <= reg_a * reg_b;
		if (cmd.latch) ins_q <= instr;
		if (cmd.op_cap) begin
			case (cmd.slot)
				srme_pkg::SLOT_A: a_q <= (slot_mode == srme_pkg::MODE_REG) ? slot_val :
					(slot_mode == srme_pkg::MODE_IMM) ? slot_imm : mem_rd_q;
				srme_pkg::SLOT_B: b_q <= (slot_mode == srme_pkg::MODE_REG) ? slot_val :
					(slot_mode == srme_pkg::MODE_IMM) ? slot_imm : mem_rd_q;
				default: d_q <= (slot_mode == srme_pkg::MODE_REG) ? slot_val :
					(slot_mode == srme_pkg::MODE_IMM) ? '0 : mem_rd_q;
			endcase
		end
	end

	// Commit: evaluate operation, write back, advance pc
	logic            wr_en, st_stop, pv, pchar;
	logic [2:0]      st;
	srme_pkg::word_t wval, pc_new;
	logic            take;

	always_comb begin
		wr_en   = 1'b0;
		wval    = '0;
		st      = srme_pkg::ST_OK;
		st_stop = 1'b0;
		pv      = 1'b0;
		pchar   = 1'b0;
		take    = 1'b0;
		case (ins_q.opcode)
			srme_pkg::OP_MOV: begin
				wr_en = 1'b1;
				wval  = a_q;
			end
			srme_pkg::OP_ADD, srme_pkg::OP_SUB, srme_pkg::OP_MUL, srme_pkg::OP_DIV: begin
				if (ins_q.dest_mode != srme_pkg::MODE_REG || ins_q.a_mode != srme_pkg::MODE_REG
						|| ins_q.b_mode != srme_pkg::MODE_REG) begin
					st      = srme_pkg::ST_KIND;
					st_stop = 1'b1;
				end else if (ins_q.opcode == srme_pkg::OP_DIV && reg_b == '0) begin
					st      = srme_pkg::ST_DIV0;
					st_stop = 1'b1;
				end else begin
					wr_en = 1'b1;
					case (ins_q.opcode)
						srme_pkg::OP_ADD: wval = reg_a + reg_b;
						srme_pkg::OP_SUB: wval = reg_a - reg_b;
						srme_pkg::OP_MUL: wval = prod_q;
						default:          wval = quot;
					endcase
				end
			end
			srme_pkg::OP_INC: begin
				wr_en = 1'b1;
				wval  = d_q + 1'b1;
			end
			srme_pkg::OP_JEQ: take = (cmp_q == '0);
			srme_pkg::OP_JLT: take = cmp_q[srme_pkg::WordBits-1];
			srme_pkg::OP_JGT: take = (cmp_q != '0) && !cmp_q[srme_pkg::WordBits-1];
			srme_pkg::OP_PUSH: begin
				if (sp_q >= (srme_pkg::StackAw+1)'(srme_pkg::StackDepth)) begin
					st      = srme_pkg::ST_OVER;
					st_stop = 1'b1;
				end
			end
			srme_pkg::OP_POP: begin
				if (sp_q == '0) begin
					st      = srme_pkg::ST_UNDER;
					st_stop = 1'b1;
				end else begin
					wr_en = 1'b1;
					wval  = stk_rd_q;
				end
			end
			srme_pkg::OP_INT: begin
				if (a_q == '0 || a_q == srme_pkg::word_t'(2)) begin
					pv    = 1'b1;
					pchar = (a_q == srme_pkg::word_t'(2));
				end else if (a_q == srme_pkg::word_t'(1)) begin
					st_stop = 1'b1;
				end
			end
			default: ;
		endcase
		pc_new = regs_q[srme_pkg::PcReg];
		if (take) pc_new = a_q;
		if (!st_stop) pc_new = pc_new + 1'b1;
	end

	logic commit_live;
	assign commit_live = cmd.commit && !halt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < srme_pkg::NumRegs; i++) regs_q[i] <= '0;
			cmp_q  <= '0;
			sp_q   <= '0;
			halt_q <= 1'b0;
		end else if (commit_live) begin
			if (wr_en && ins_q.dest_mode == srme_pkg::MODE_REG
					&& ins_q.dest_value < 12'(srme_pkg::PcReg))
				regs_q[ins_q.dest_value[3:0]] <= wval;
			// a register write to the pc takes priority over the pc update unless halting
			if (!(wr_en && ins_q.dest_mode == srme_pkg::MODE_REG
					&& ins_q.dest_value == 12'(srme_pkg::PcReg)) || st_stop)
				regs_q[srme_pkg::PcReg] <= pc_new;
			else
				regs_q[srme_pkg::PcReg] <= wval + 1'b1;
			if (ins_q.opcode == srme_pkg::OP_CMP) cmp_q <= a_q - b_q;
			if (ins_q.opcode == srme_pkg::OP_PUSH && !st_stop) sp_q <= sp_q + 1'b1;
			if (ins_q.opcode == srme_pkg::OP_POP && !st_stop) sp_q <= sp_q - 1'b1;
			if (st_stop) halt_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_live) begin
			if (wr_en && (ins_q.dest_mode == srme_pkg::MODE_DIR
					|| ins_q.dest_mode == srme_pkg::MODE_IND))
				mem[wr_adr_q] <= wval;
			else if (ins_q.opcode == srme_pkg::OP_PMOV)
				mem[a_q[srme_pkg::MemAw-1:0]] <= b_q;
			if (ins_q.opcode == srme_pkg::OP_PUSH && !st_stop)
				stk[sp_q[srme_pkg::StackAw-1:0]] <= a_q;
		end
		if (cmd.out_load) begin
			if (commit_live) begin
				res.next_pc       <= (wr_en && ins_q.dest_mode == srme_pkg::MODE_REG
					&& ins_q.dest_value == 12'(srme_pkg::PcReg) && !st_stop) ? wval + 1'b1 : pc_new;
				res.print_valid   <= pv;
				res.print_is_char <= pchar;
				res.print_value   <= pv ? regs_q[0] : '0;
				res.halted        <= st_stop;
				res.status        <= st;
			end else begin
				res.next_pc       <= regs_q[srme_pkg::PcReg];
				res.print_valid   <= 1'b0;
				res.print_is_char <= 1'b0;
				res.print_value   <= '0;
				res.halted        <= 1'b1;
				res.status        <= srme_pkg::ST_OK;
			end
		end
	end

	assign stat.div_busy  = div_busy;
	assign stat.opcode    = ins_q.opcode;
	assign stat.dest_mode = ins_q.dest_mode;
	assign stat.a_mode    = ins_q.a_mode;
	assign stat.b_mode    = ins_q.b_mode;
	assign stat.halted    = halt_q;

	`include "small_register_machine_executor_core_assert.svh"
	`SRM_ASSERT_NEXT(a_halt_sticky, clk, arst_n, halt_q, halt_q)
	`SRM_ASSERT_IMP(a_sp_bound, clk, arst_n, 1'b1,
		sp_q <= (srme_pkg::StackAw+1)'(srme_pkg::StackDepth))
	`SRM_ASSERT_NEXT(a_halt_freezes_pc, clk, arst_n, halt_q,
		regs_q[srme_pkg::PcReg] == $past(regs_q[srme_pkg::PcReg]))
endmodule

### design/srme_ctrl.sv
// Sequencer: resolves operands one memory access at a time, then commits.
module srme_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	srme_in_if.sink            in_ch,
	input  logic               out_ready,
	output logic               out_valid,
	input  srme_pkg::dp_stat_t stat,
	output srme_pkg::dp_cmd_t  cmd
);
	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_SLOT  = 10'b0000000010,  // pick next operand, issue first read
		S_RD1   = 10'b0000000100,  // first read data valid
		S_RD2   = 10'b0000001000,  // indirect read data valid
		S_DIVGO = 10'b0000010000,
		S_DIVW  = 10'b0000100000,
		S_MUL   = 10'b0001000000,
		S_COMM  = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_DADR  = 10'b1000000000   // re-read dest address for write back
	} state_t;

	state_t state_q, state_d;
	srme_pkg::slot_t slot_q, slot_d;
	logic            out_valid_q;

	function automatic logic [1:0] mode_of(input srme_pkg::slot_t s, input srme_pkg::dp_stat_t st);
		logic [1:0] m;
		case (s)
			srme_pkg::SLOT_A: m = st.a_mode;
			srme_pkg::SLOT_B: m = st.b_mode;
			default:          m = st.dest_mode;
		endcase
		return m;
	endfunction

	// Slot use per opcode: A, B, and D (read of destination for inc)
	logic use_b, use_d;
	always_comb begin
		use_b = (stat.opcode == srme_pkg::OP_PMOV) || (stat.opcode == srme_pkg::OP_CMP);
		use_d = (stat.opcode == srme_pkg::OP_INC);
	end

	logic [1:0] cur_mode;
	logic       dest_mem;
	assign cur_mode = mode_of(slot_q, stat);
	assign dest_mem = (stat.dest_mode == srme_pkg::MODE_DIR || stat.dest_mode == srme_pkg::MODE_IND)
		&& (stat.opcode == srme_pkg::OP_MOV || stat.opcode == srme_pkg::OP_INC
		|| stat.opcode == srme_pkg::OP_POP);

	always_comb begin
		state_d = state_q;
		slot_d  = slot_q;
		cmd     = '0;
		cmd.slot = slot_q;
		case (state_q)
			S_IDLE: begin
				if (in_ch.valid && !out_valid_q) begin
					cmd.latch = 1'b1;
					slot_d    = srme_pkg::SLOT_A;
					state_d   = S_SLOT;
				end
			end
			S_SLOT: begin
				if (stat.halted) begin
					state_d = S_OUT;
				end else if (slot_q == srme_pkg::SLOT_D && !use_d) begin
					state_d = dest_mem ? S_DADR : S_COMM;
					if (stat.opcode == srme_pkg::OP_DIV) state_d = S_DIVGO;
					if (stat.opcode == srme_pkg::OP_MUL) state_d = S_MUL;
					if (dest_mem) cmd.mem_rd = 1'b1;
				end else begin
					cmd.mem_rd = 1'b1;
					state_d    = S_RD1;
				end
			end
			S_RD1: begin
				if (cur_mode == srme_pkg::MODE_IND) begin
					cmd.mem_rd  = 1'b1;
					cmd.mem_ind = 1'b1;
					state_d     = S_RD2;
				end else begin
					cmd.op_cap = 1'b1;
					state_d    = S_SLOT;
					slot_d     = (slot_q == srme_pkg::SLOT_A) ?
						(use_b ? srme_pkg::SLOT_B : srme_pkg::SLOT_D) : srme_pkg::SLOT_D;
					if (slot_q == srme_pkg::SLOT_D) state_d = dest_mem ? S_DADR : S_COMM;
					if (slot_q == srme_pkg::SLOT_D && dest_mem) state_d = S_COMM;
				end
			end
			S_RD2: begin
				cmd.op_cap = 1'b1;
				slot_d     = (slot_q == srme_pkg::SLOT_A) ?
					(use_b ? srme_pkg::SLOT_B : srme_pkg::SLOT_D) : srme_pkg::SLOT_D;
				state_d    = (slot_q == srme_pkg::SLOT_D) ? S_COMM : S_SLOT;
			end
			S_DADR: begin
				// read for write address issued; indirect needs the second hop
				if (stat.dest_mode == srme_pkg::MODE_IND) begin
					cmd.slot    = srme_pkg::SLOT_D;
					cmd.mem_rd  = 1'b1;
					cmd.mem_ind = 1'b1;
				end
				state_d = S_COMM;
			end
			S_MUL:   state_d = S_COMM;
			S_DIVGO: begin
				if (stat.dest_mode == srme_pkg::MODE_REG && stat.a_mode == srme_pkg::MODE_REG
						&& stat.b_mode == srme_pkg::MODE_REG)
					cmd.div_start = 1'b1;
				state_d = S_DIVW;
			end
			S_DIVW:  if (!stat.div_busy) state_d = S_COMM;
			S_COMM: begin
				cmd.commit   = 1'b1;
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			S_OUT: begin
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Dest slot for memory destinations uses indirect hop address from slot D
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= srme_pkg::SLOT_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			slot_q  <= slot_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ch.ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid   = out_valid_q;

	`include "small_register_machine_executor_core_assert.svh"
	`SRM_ASSERT_IMP(a_no_accept_busy, clk, arst_n, in_ch.ready, state_q == S_IDLE)
	`SRM_ASSERT_NEXT(a_commit_then_idle, clk, arst_n, cmd.commit, state_q == S_IDLE)
	`SRM_ASSERT_NEXT(a_load_gives_valid, clk, arst_n, cmd.out_load, out_valid_q)
endmodule

### design/small_register_machine_executor_core.sv
// Channel  Dir  Payload                                    Handshake
// in_ch    in   opcode, modes, dest/a/b values             valid/ready
// out_ch   out  next_pc, print fields, halted, status      valid/ready
//
// An item goes through slot A read and capture, a dest step and commit;
// a second source adds a read and capture, an indirect source a second
// read, a mov/pop memory dest an address read, inc a dest read (with its
// hop if indirect), a multiply step, a divide start and bit-serial wait.
// One item in flight; the next is taken once the result has left the output.
// arst_n clears registers, compare, stack count, halt flag and sequencer.
module small_register_machine_executor_core (
	input  logic        clk,
	input  logic        arst_n,
	srme_in_if.sink     in_ch,
	srme_out_if.source  out_ch
);
	srme_pkg::dp_cmd_t  cmd;
	srme_pkg::dp_stat_t stat;

	// Sequencer: walks operand slots and drives the datapath
	srme_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: state, memories, arithmetic and the result register
	srme_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (in_ch.payload),
		.cmd    (cmd),
		.stat   (stat),
		.res    (out_ch.payload)
	);
endmodule
